>>> rtl/core/clt_pkg.sv
// shared types and constants for the compacting list table
// no dependencies; imported by every module of the block
package clt_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int CAP_W   = 5;
    localparam int VAL_W   = 32;
    localparam int IN_W    = 40;
    localparam int OUT_W   = 16;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_MISS  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic exec;
    } dp_cmd_t;

    // one result word
    typedef struct packed {
        logic             is_full;
        logic             is_empty;
        logic [CNT_W-1:0] occupancy;
        status_t          status;
    } result_t;

endpackage

>>> rtl/core/clt_ctrl.sv
// handshake controller for the compacting list table
// depends on clt_pkg; drives the datapath execute command
module clt_ctrl
    import clt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output dp_cmd_t dp_cmd
);

    typedef enum logic {
        S_EMPTY,
        S_HOLD
    } state_t;

    state_t state_reg, state_next;

    // a new word may enter while the held result leaves
    assign in_ready    = (state_reg == S_EMPTY) || out_ready;
    assign out_valid   = (state_reg == S_HOLD);
    assign dp_cmd.exec = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_EMPTY:
            begin
                if (dp_cmd.exec)
                    state_next = S_HOLD;
            end
            S_HOLD:
            begin
                if (out_ready && !dp_cmd.exec)
                    state_next = S_EMPTY;
            end
            default: state_next = S_EMPTY;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_EMPTY;
        else
            state_reg <= state_next;
    end

endmodule

>>> rtl/core/clt_datapath.sv
// slot registers, live count, capacity and result register
// depends on clt_pkg; stepped by the execute command from clt_ctrl
module clt_datapath
    import clt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  dp_cmd_t          dp_cmd,
    input  cmd_t             cmd,
    input  logic [VAL_W-1:0] value,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata,
    output result_t          result
);

    logic [VAL_W-1:0] slots_reg [DEPTH];
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CAP_W-1:0] cap_reg;
    result_t          result_reg, result_next;

    logic [CNT_W-1:0] eff_cap;
    logic             full_now;
    logic [DEPTH-1:0] match;
    logic [DEPTH-1:0] from_hit;
    logic             any_hit;
    logic             do_append;
    logic             do_delete;
    status_t          status;

    always_comb
    begin
        eff_cap  = (CNT_W'(cap_reg) > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(cap_reg);
        full_now = (count_reg >= eff_cap);
        for (int i = 0; i < DEPTH; i++)
            match[i] = (CNT_W'(i) < count_reg) && (slots_reg[i] == value);
        // slots at or above the first hit
        from_hit[0] = match[0];
        for (int i = 1; i < DEPTH; i++)
            from_hit[i] = from_hit[i-1] | match[i];
        any_hit = from_hit[DEPTH-1];
    end

    always_comb
    begin
        status     = ST_DONE;
        do_append  = 1'b0;
        do_delete  = 1'b0;
        count_next = count_reg;
        case (cmd)
            CMD_APPEND:
            begin
                if (full_now)
                    status = ST_FULL;
                else
                begin
                    do_append  = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_SEARCH, CMD_DELETE:
            begin
                if (count_reg == '0)
                    status = ST_EMPTY;
                else if (!any_hit)
                    status = ST_MISS;
                else if (cmd == CMD_DELETE)
                begin
                    do_delete  = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default: status = ST_DONE;
        endcase
        result_next.status    = status;
        result_next.occupancy = count_next;
        result_next.is_empty  = (count_next == '0);
        result_next.is_full   = (count_next >= eff_cap);
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.exec)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                if (do_append && (count_reg[IDX_W-1:0] == IDX_W'(i)))
                    slots_reg[i] <= value;
                else if (do_delete && from_hit[i] && (i + 1 < DEPTH))
                    slots_reg[i] <= slots_reg[(i + 1) % DEPTH];
            end
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            cap_reg   <= CAP_RESET;
        end
        else
        begin
            if (dp_cmd.exec)
                count_reg <= count_next;
            if (cfg_we)
                cap_reg <= cfg_wdata;
        end
    end

    assign result = result_reg;

endmodule

>>> rtl/core/compacting_list_table_core.sv
// top level of the compacting list table
// depends on clt_pkg, clt_ctrl and clt_datapath
//
// usage:
//   s_axis carries one command word: append, search or delete-first-match of
//   a signed 32-bit value. m_axis returns exactly one result word per command:
//   status, occupancy after the command, empty and full flags.
//   cfg_we/cfg_wdata set the capacity (1..16, larger values clamp to 16,
//   zero makes the table always full); write only while the block is idle.
// timing:
//   every command is executed when accepted; its result is registered and shows on
//   m_axis the cycle after acceptance. all 16 slots compare in parallel and
//   a delete shifts the tail down in the same cycle, so one word per cycle
//   is sustained while m_axis_tready stays high.
// stall:
//   a result waits in the output register; s_axis_tready stays high only
//   when that register is empty or is being drained in the same cycle.
// reset:
//   rst_n clears the live count, the output valid and sets capacity to 16;
//   slot contents are not cleared and are never read before written.
module compacting_list_table_core
    import clt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,  // [1:0] cmd, [33:2] value, rest zero
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,  // [1:0] status, [6:2] occupancy,
                                            // [7] is_empty, [8] is_full, rest zero
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata
);

    dp_cmd_t dp_cmd;
    result_t result;
    cmd_t    cmd;

    assign cmd = cmd_t'(s_axis_tdata[1:0]);

    clt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .dp_cmd    (dp_cmd)
    );

    clt_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .dp_cmd    (dp_cmd),
        .cmd       (cmd),
        .value     (s_axis_tdata[VAL_W+1:2]),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .result    (result)
    );

    assign m_axis_tdata = OUT_W'({result.is_full, result.is_empty,
                                  result.occupancy, result.status});

endmodule
